// File: hw/rtl/llr_bd_pkg.sv
`timescale 1ns / 1ps

package llr_bd_pkg;

    localparam int LLR_W    = 8;
    localparam int KEPT_W   = 8;
    localparam int ADDR_W   = 9;
    localparam int ROW_W    = 5;
    localparam int COL_W    = 4;
    localparam int OP_W     = 2;

    localparam logic [KEPT_W-1:0] KEPT_RESET = 8'd236;

    typedef logic signed [LLR_W-1:0] llr_t;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_ERASE = 2'd1,
        OP_READ  = 2'd2,
        OP_RSVD  = 2'd3
    } op_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        llr_t              wdata;
    } mem_req_t;

endpackage

// File: hw/rtl/llr_bd_mem.sv
`timescale 1ns / 1ps

module llr_bd_mem #(
    parameter int CELLS = 252
) (
    input  logic                 clk,
    input  llr_bd_pkg::mem_req_t req,
    output llr_bd_pkg::llr_t     rdata
);

    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;

    llr_bd_pkg::llr_t mem [CELLS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr[AW-1:0]] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.addr[AW-1:0]];
        end
    end

endmodule

// File: hw/rtl/llr_bd_ctrl.sv
`timescale 1ns / 1ps

module llr_bd_ctrl #(
    parameter int ROWS = 28,
    parameter int COLS = 9
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [llr_bd_pkg::KEPT_W-1:0]     kept_count,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [llr_bd_pkg::OP_W-1:0]       operation,
    input  logic [llr_bd_pkg::COL_W-1:0]      column,
    input  logic [llr_bd_pkg::ROW_W-1:0]      row,
    input  llr_bd_pkg::llr_t                  llr_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output llr_bd_pkg::llr_t                  llr_out,
    output logic                              read_valid,
    output logic                              last_entry,
    output logic                              rejected,
    output llr_bd_pkg::mem_req_t              mem_req,
    input  llr_bd_pkg::llr_t                  mem_rdata
);

    localparam int CELLS = ROWS * COLS;
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LIM_W = llr_bd_pkg::ADDR_W + 1;

    typedef enum logic {
        S_IDLE,
        S_ERASE
    } state_t;

    state_t                             state_reg, state_next;
    logic [llr_bd_pkg::KEPT_W-1:0]      ptr_reg, ptr_next;
    logic [RW-1:0]                      erase_row_reg, erase_row_next;
    logic [llr_bd_pkg::ADDR_W-1:0]      erase_addr_reg, erase_addr_next;
    logic                               out_valid_reg, out_valid_next;
    logic                               read_valid_reg, read_valid_next;
    logic                               last_reg, last_next;
    logic                               rej_reg, rej_next;

    logic                               accept;
    logic [LIM_W-1:0]                   lim;
    logic [LIM_W-1:0]                   ptr_inc;
    logic                               wr_ok;
    logic                               col_ok;

    assign in_ready   = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept     = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign read_valid = read_valid_reg;
    assign last_entry = last_reg;
    assign rejected   = rej_reg;
    assign llr_out    = read_valid_reg ? mem_rdata : '0;

    assign col_ok  = int'(column) < COLS;
    assign wr_ok   = col_ok && (int'(row) < ROWS);
    assign ptr_inc = LIM_W'(ptr_reg) + LIM_W'(1);

    always_comb
    begin
        if (kept_count == '0)
            lim = LIM_W'(1);
        else if (int'(kept_count) > CELLS)
            lim = LIM_W'(CELLS);
        else
            lim = LIM_W'(kept_count);
    end

    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        erase_row_next  = erase_row_reg;
        erase_addr_next = erase_addr_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        read_valid_next = read_valid_reg;
        last_next       = last_reg;
        rej_next        = rej_reg;
        mem_req         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    read_valid_next = 1'b0;
                    last_next       = 1'b0;
                    rej_next        = 1'b0;
                    case (llr_bd_pkg::op_t'(operation))
                        llr_bd_pkg::OP_WRITE:
                        begin
                            out_valid_next = 1'b1;
                            if (wr_ok)
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.addr  = llr_bd_pkg::ADDR_W'(row)
                                                * llr_bd_pkg::ADDR_W'(COLS)
                                                + llr_bd_pkg::ADDR_W'(column);
                                mem_req.wdata = llr_in;
                            end
                            else
                            begin
                                rej_next = 1'b1;
                            end
                        end
                        llr_bd_pkg::OP_ERASE:
                        begin
                            if (col_ok)
                            begin
                                state_next      = S_ERASE;
                                erase_row_next  = '0;
                                erase_addr_next = llr_bd_pkg::ADDR_W'(column);
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                                rej_next       = 1'b1;
                            end
                        end
                        llr_bd_pkg::OP_READ:
                        begin
                            out_valid_next  = 1'b1;
                            read_valid_next = 1'b1;
                            mem_req.re      = 1'b1;
                            mem_req.addr    = llr_bd_pkg::ADDR_W'(ptr_reg);
                            if (ptr_inc >= lim)
                            begin
                                last_next = 1'b1;
                                ptr_next  = '0;
                            end
                            else
                            begin
                                ptr_next = ptr_inc[llr_bd_pkg::KEPT_W-1:0];
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            rej_next       = 1'b1;
                        end
                    endcase
                end
            end
            S_ERASE:
            begin
                mem_req.we      = 1'b1;
                mem_req.addr    = erase_addr_reg;
                mem_req.wdata   = '0;
                erase_row_next  = erase_row_reg + RW'(1);
                erase_addr_next = erase_addr_reg + llr_bd_pkg::ADDR_W'(COLS);
                if (int'(erase_row_reg) == ROWS - 1)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ptr_reg        <= '0;
            erase_row_reg  <= '0;
            erase_addr_reg <= '0;
            out_valid_reg  <= 1'b0;
            read_valid_reg <= 1'b0;
            last_reg       <= 1'b0;
            rej_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            erase_row_reg  <= erase_row_next;
            erase_addr_reg <= erase_addr_next;
            out_valid_reg  <= out_valid_next;
            read_valid_reg <= read_valid_next;
            last_reg       <= last_next;
            rej_reg        <= rej_next;
        end
    end

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.we && mem_req.re))
        else $error("memory read and write in the same cycle");

    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(ptr_reg) < CELLS)
        else $error("read pointer beyond matrix");

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == llr_bd_pkg::OP_READ) |=> (out_valid_reg && read_valid_reg))
        else $error("read transfer gave no read result");

    a_erase_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ERASE) |-> (!out_valid_reg && !in_ready))
        else $error("output or input active during column erase");

    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == llr_bd_pkg::OP_READ && last_next) |=> (ptr_reg == '0))
        else $error("pointer did not wrap after last entry");

endmodule

// File: hw/rtl/llr_block_deinterleaver_top.sv
`timescale 1ns / 1ps
// LLR block deinterleaver, ROWS x COLS matrix of signed 8-bit soft values.
// Input channel (in_valid/in_ready) carries operation, column, row, llr_in:
//   write stores llr_in at row*COLS+column, erase zeroes one column,
//   read returns the next row-major entry up to kept_count, then wraps.
// Every input transfer yields exactly one result on the output channel
// (out_valid/out_ready): llr_out, read_valid, last_entry, rejected.
// Out-of-range indexes and the reserved operation are flagged as rejected.
// Results for write, read and rejected items are registered and valid in the
// cycle after the input transfer; a column erase performs one memory write
// per row, and its result appears at the end.
// Throughput: one item per cycle while the receiver takes results, set by the
// single memory port; erase holds the input off until its column is cleared.
// kept_count is written through cfg_valid/cfg_ready (always ready); the user
// must write it only while idle, unenforced by the block. Reset clears the
// read pointer and sets kept_count to 236; the matrix is not cleared and must
// be written before it is read. When the receiver stalls the result is held
// in the output register and no new input is taken until it is transferred.
module llr_block_deinterleaver_top #(
    parameter int ROWS = 28,
    parameter int COLS = 9
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [llr_bd_pkg::KEPT_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [llr_bd_pkg::OP_W-1:0]   operation,
    input  logic [llr_bd_pkg::COL_W-1:0]  column,
    input  logic [llr_bd_pkg::ROW_W-1:0]  row,
    input  llr_bd_pkg::llr_t              llr_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output llr_bd_pkg::llr_t              llr_out,
    output logic                          read_valid,
    output logic                          last_entry,
    output logic                          rejected
);

    logic [llr_bd_pkg::KEPT_W-1:0] kept_reg;
    llr_bd_pkg::mem_req_t          mem_req;
    llr_bd_pkg::llr_t              mem_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kept_reg <= llr_bd_pkg::KEPT_RESET;
        else if (cfg_valid && cfg_ready)
            kept_reg <= cfg_data;
    end

    llr_bd_ctrl #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .kept_count (kept_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .column     (column),
        .row        (row),
        .llr_in     (llr_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .llr_out    (llr_out),
        .read_valid (read_valid),
        .last_entry (last_entry),
        .rejected   (rejected),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata)
    );

    llr_bd_mem #(
        .CELLS (ROWS * COLS)
    ) u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

endmodule
